// ----- hdl/ray_triangle_intersect_core_assert.svh -----
// Assertion macros shared by the checker.
`ifndef RAY_TRIANGLE_INTERSECT_CORE_ASSERT_SVH
`define RAY_TRIANGLE_INTERSECT_CORE_ASSERT_SVH

// Clocked property, disabled while reset is asserted.
`define RTI_ASSERT(lbl, ck, rstn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) prop) \
		else $error("ray_triangle_intersect_core: assertion failed");

// A stalled transfer holds the given signal.
`define RTI_ASSERT_HOLD(lbl, ck, rstn, vld, stl, sig) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (vld && stl) |=> $stable(sig)) \
		else $error("ray_triangle_intersect_core: stalled payload changed");

`endif

// ----- hdl/rti_pkg.sv -----
`timescale 1ns / 1ps
package rti_pkg;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int DIST_WIDTH      = 31;
	localparam int MDET_WIDTH      = 32;
	localparam int NUM_VERT        = 3;

	typedef enum logic {
		FUNC_LOAD = 1'b0,
		FUNC_RAY  = 1'b1
	} func_t;

	typedef enum logic {
		CFG_MIN_ABS_DET = 1'b0,
		CFG_MIN_DIST    = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic valid;
		logic miss;
	} stage_ctl_t;
endpackage

// ----- hdl/rti_front.sv -----
`timescale 1ns / 1ps
module rti_front import rti_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEF,
	localparam int EW = CW + 1,
	localparam int PW = 2 * EW,
	localparam int XW = PW + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [CW-1:0] v0 [3],
	input  logic signed [CW-1:0] v1 [3],
	input  logic signed [CW-1:0] v2 [3],
	input  logic signed [CW-1:0] org [3],
	input  logic signed [CW-1:0] dir [3],
	output stage_ctl_t           ctl,
	output logic signed [EW-1:0] e1 [3],
	output logic signed [EW-1:0] e2 [3],
	output logic signed [EW-1:0] sv [3],
	output logic signed [EW-1:0] dv [3],
	output logic signed [XW-1:0] h [3],
	output logic signed [XW-1:0] q [3]
);
	localparam int NX [3] = '{1, 2, 0};
	localparam int PX [3] = '{2, 0, 1};

	logic                 vld_s1, vld_s2, vld_s3;
	logic signed [EW-1:0] e1_s1 [3], e2_s1 [3], s_s1 [3], d_s1 [3];
	logic signed [EW-1:0] e1_s2 [3], e2_s2 [3], s_s2 [3], d_s2 [3];
	logic signed [EW-1:0] e1_s3 [3], e2_s3 [3], s_s3 [3], d_s3 [3];
	logic signed [PW-1:0] hp_s2 [3], hn_s2 [3], qp_s2 [3], qn_s2 [3];
	logic signed [XW-1:0] h_s3 [3], q_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				e1_s1[i] <= EW'(v1[i]) - EW'(v0[i]);
				e2_s1[i] <= EW'(v2[i]) - EW'(v0[i]);
				s_s1[i]  <= EW'(org[i]) - EW'(v0[i]);
				d_s1[i]  <= EW'(dir[i]);

				hp_s2[i] <= PW'(d_s1[NX[i]]) * PW'(e2_s1[PX[i]]);
				hn_s2[i] <= PW'(d_s1[PX[i]]) * PW'(e2_s1[NX[i]]);
				qp_s2[i] <= PW'(s_s1[NX[i]]) * PW'(e1_s1[PX[i]]);
				qn_s2[i] <= PW'(s_s1[PX[i]]) * PW'(e1_s1[NX[i]]);
				e1_s2[i] <= e1_s1[i];
				e2_s2[i] <= e2_s1[i];
				s_s2[i]  <= s_s1[i];
				d_s2[i]  <= d_s1[i];

				h_s3[i]  <= XW'(hp_s2[i]) - XW'(hn_s2[i]);
				q_s3[i]  <= XW'(qp_s2[i]) - XW'(qn_s2[i]);
				e1_s3[i] <= e1_s2[i];
				e2_s3[i] <= e2_s2[i];
				s_s3[i]  <= s_s2[i];
				d_s3[i]  <= d_s2[i];
			end
		end
	end

	assign ctl.valid = vld_s3;
	assign ctl.miss  = 1'b0;
	assign e1 = e1_s3;
	assign e2 = e2_s3;
	assign sv = s_s3;
	assign dv = d_s3;
	assign h  = h_s3;
	assign q  = q_s3;
endmodule

// ----- hdl/rti_dot.sv -----
`timescale 1ns / 1ps
module rti_dot import rti_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEF,
	localparam int EW = CW + 1,
	localparam int XW = 2 * EW + 1,
	localparam int NW = EW + XW + 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  stage_ctl_t            in_ctl,
	input  logic signed [EW-1:0]  e1 [3],
	input  logic signed [EW-1:0]  e2 [3],
	input  logic signed [EW-1:0]  sv [3],
	input  logic signed [EW-1:0]  dv [3],
	input  logic signed [XW-1:0]  h [3],
	input  logic signed [XW-1:0]  q [3],
	input  logic [MDET_WIDTH-1:0] min_abs_det,
	output stage_ctl_t            ctl,
	output logic [NW-1:0]         num [4]
);
	localparam int LOW = (XW + 1) / 2;
	localparam int HIW = XW - LOW;
	localparam int LPW = EW + LOW + 1;
	localparam int HPW = EW + HIW;
	localparam int TW  = EW + XW;

	logic signed [EW-1:0]  a_w [4][3];
	logic signed [XW-1:0]  b_w [4][3];
	logic                  vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic signed [LPW-1:0] lo_s4 [4][3];
	logic signed [HPW-1:0] hi_s4 [4][3];
	logic signed [TW-1:0]  prod_s5 [4][3];
	logic signed [NW-1:0]  dot_s6 [4];
	logic signed [NW-1:0]  fold_s7 [4];
	logic                  zero_s7;
	logic                  miss_s8;
	logic [NW-1:0]         num_s8 [4];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a_w[0][i] = e1[i];
			b_w[0][i] = h[i];
			a_w[1][i] = sv[i];
			b_w[1][i] = h[i];
			a_w[2][i] = dv[i];
			b_w[2][i] = q[i];
			a_w[3][i] = e2[i];
			b_w[3][i] = q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s4 <= in_ctl.valid;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int m = 0; m < 4; m++) begin
				for (int i = 0; i < 3; i++) begin
					lo_s4[m][i] <= LPW'(a_w[m][i]) * $signed({1'b0, b_w[m][i][LOW-1:0]});
					hi_s4[m][i] <= HPW'(a_w[m][i]) * HPW'($signed(b_w[m][i][XW-1:LOW]));
					prod_s5[m][i] <= (TW'(hi_s4[m][i]) <<< LOW) + TW'(lo_s4[m][i]);
				end
				dot_s6[m] <= NW'(prod_s5[m][0]) + NW'(prod_s5[m][1]) + NW'(prod_s5[m][2]);
				fold_s7[m] <= dot_s6[0][NW-1] ? -dot_s6[m] : dot_s6[m];
				num_s8[m] <= fold_s7[m];
			end
			zero_s7 <= (dot_s6[0] == '0);
			miss_s8 <= zero_s7
				|| ($unsigned(fold_s7[0]) < NW'(min_abs_det))
				|| fold_s7[1][NW-1]
				|| (fold_s7[0] < fold_s7[1])
				|| fold_s7[2][NW-1]
				|| ((NW+1)'(fold_s7[0]) < ((NW+1)'(fold_s7[1]) + (NW+1)'(fold_s7[2])))
				|| fold_s7[3][NW-1];
		end
	end

	assign ctl.valid = vld_s8;
	assign ctl.miss  = miss_s8;
	assign num = num_s8;
endmodule

// ----- hdl/rti_div.sv -----
`timescale 1ns / 1ps
module rti_div import rti_pkg::*; #(
	parameter int NW   = 102,
	parameter int FRAC = FRAC_BITS_DEF,
	localparam int QW  = DIST_WIDTH,
	localparam int RW  = NW + FRAC + QW
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  stage_ctl_t      in_ctl,
	input  logic [NW-1:0]   num [4],
	output stage_ctl_t      ctl,
	output logic [QW-1:0]   quo_t,
	output logic [FRAC:0]   quo_u,
	output logic [FRAC:0]   quo_v
);
	stage_ctl_t    ctl_s [QW+1];
	logic          ovf_s [QW+1];
	logic [RW-1:0] den_s [QW+1];
	logic [RW-1:0] rem_s [QW+1][3];
	logic [QW-1:0] quo_s [QW+1][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (en) begin
			ctl_s[0] <= in_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0] <= RW'(num[0]);
			ovf_s[0] <= (RW'(num[3]) << FRAC) >= (RW'(num[0]) << QW);
			rem_s[0][0] <= RW'(num[3]) << FRAC;
			rem_s[0][1] <= RW'(num[1]) << FRAC;
			rem_s[0][2] <= RW'(num[2]) << FRAC;
			for (int n = 0; n < 3; n++) begin
				quo_s[0][n] <= '0;
			end
		end
	end

	for (genvar g = 0; g < QW; g++) begin : g_stage
		localparam int K = QW - 1 - g;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[g+1] <= '0;
			end else if (en) begin
				ctl_s[g+1] <= ctl_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[g+1] <= den_s[g];
				ovf_s[g+1] <= ovf_s[g];
				for (int n = 0; n < 3; n++) begin
					if (rem_s[g][n] >= (den_s[g] << K)) begin
						rem_s[g+1][n] <= rem_s[g][n] - (den_s[g] << K);
						quo_s[g+1][n] <= quo_s[g][n] | (QW'(1) << K);
					end else begin
						rem_s[g+1][n] <= rem_s[g][n];
						quo_s[g+1][n] <= quo_s[g][n];
					end
				end
			end
		end
	end

	assign ctl   = ctl_s[QW];
	assign quo_t = ovf_s[QW] ? '1 : quo_s[QW][0];
	assign quo_u = quo_s[QW][1][FRAC:0];
	assign quo_v = quo_s[QW][2][FRAC:0];
endmodule

// ----- hdl/ray_triangle_intersect_core.sv -----
`timescale 1ns / 1ps
// Moller-Trumbore ray/triangle test, signed fixed point (Q16.16 by default).
// Input channel (in_valid/in_stall): func selects a vertex load or a ray test.
//   A load writes vertex vertex_sel (0..2) at its transfer and yields no result;
//   vertex_sel 3 is dropped. A ray test yields exactly one result.
// Output channel (out_valid/out_stall): hit, distance, bary_u, bary_v, bary_w;
//   on a miss every field is zero.
// Config port: cfg_we/cfg_addr/cfg_wdata; index 0 min_abs_det, 1 min_distance.
//   Write only while no ray is in flight.
// Pipeline, from ray transfer to result valid: edge and cross products,
//   split multiplies and dot sums with sign folding and bound checks, a
//   radix-2 restoring divider (one setup stage, then 31 stages that each
//   produce one quotient bit), then 1 output register.
// Throughput: one item per cycle unless stalled; every stage advances together.
// Stall: while out_valid is high and out_stall is high the whole pipeline holds
//   and in_stall is raised; nothing is lost or repeated.
// Reset: clears the pipeline valid bits and the vertex store to zero, and sets
//   min_abs_det and min_distance to 1.
module ray_triangle_intersect_core import rti_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          func,
	input  logic [1:0]                    vertex_sel,
	input  logic signed [COORD_WIDTH-1:0] vert_x,
	input  logic signed [COORD_WIDTH-1:0] vert_y,
	input  logic signed [COORD_WIDTH-1:0] vert_z,
	input  logic signed [COORD_WIDTH-1:0] origin_x,
	input  logic signed [COORD_WIDTH-1:0] origin_y,
	input  logic signed [COORD_WIDTH-1:0] origin_z,
	input  logic signed [COORD_WIDTH-1:0] dir_x,
	input  logic signed [COORD_WIDTH-1:0] dir_y,
	input  logic signed [COORD_WIDTH-1:0] dir_z,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          hit,
	output logic [DIST_WIDTH-1:0]         distance,
	output logic [FRAC_BITS:0]            bary_u,
	output logic [FRAC_BITS:0]            bary_v,
	output logic [FRAC_BITS:0]            bary_w,
	input  logic                          cfg_we,
	input  logic                          cfg_addr,
	input  logic [MDET_WIDTH-1:0]         cfg_wdata
);
	localparam int EW = COORD_WIDTH + 1;
	localparam int XW = 2 * EW + 1;
	localparam int NW = EW + XW + 2;
	localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

	logic                          en;
	logic                          xfer_in;
	logic signed [COORD_WIDTH-1:0] vertex_q [NUM_VERT][3];
	logic signed [COORD_WIDTH-1:0] org_w [3];
	logic signed [COORD_WIDTH-1:0] dir_w [3];
	logic [MDET_WIDTH-1:0]         min_abs_det_q;
	logic [DIST_WIDTH-1:0]         min_dist_q;

	stage_ctl_t           front_ctl, dot_ctl, div_ctl;
	logic signed [EW-1:0] e1_w [3], e2_w [3], s_w [3], d_w [3];
	logic signed [XW-1:0] h_w [3], q_w [3];
	logic [NW-1:0]        num_w [4];
	logic [DIST_WIDTH-1:0] quo_t_w;
	logic [FRAC_BITS:0]   quo_u_w, quo_v_w;
	logic                 hit_w;

	logic                  vld_q, hit_q;
	logic [DIST_WIDTH-1:0] dist_q;
	logic [FRAC_BITS:0]    u_q, v_q, w_q;

	assign en       = !(vld_q && out_stall);
	assign in_stall = !en;
	assign xfer_in  = in_valid && en;

	assign org_w[0] = origin_x;
	assign org_w[1] = origin_y;
	assign org_w[2] = origin_z;
	assign dir_w[0] = dir_x;
	assign dir_w[1] = dir_y;
	assign dir_w[2] = dir_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_VERT; k++) begin
				for (int i = 0; i < 3; i++) begin
					vertex_q[k][i] <= '0;
				end
			end
		end else if (xfer_in && func == FUNC_LOAD && vertex_sel < NUM_VERT) begin
			vertex_q[vertex_sel][0] <= vert_x;
			vertex_q[vertex_sel][1] <= vert_y;
			vertex_q[vertex_sel][2] <= vert_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_abs_det_q <= MDET_WIDTH'(1);
			min_dist_q    <= DIST_WIDTH'(1);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_MIN_ABS_DET: min_abs_det_q <= cfg_wdata;
				CFG_MIN_DIST:    min_dist_q    <= cfg_wdata[DIST_WIDTH-1:0];
				default:         ;
			endcase
		end
	end

	rti_front #(.CW(COORD_WIDTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid && func == FUNC_RAY),
		.v0       (vertex_q[0]),
		.v1       (vertex_q[1]),
		.v2       (vertex_q[2]),
		.org      (org_w),
		.dir      (dir_w),
		.ctl      (front_ctl),
		.e1       (e1_w),
		.e2       (e2_w),
		.sv       (s_w),
		.dv       (d_w),
		.h        (h_w),
		.q        (q_w)
	);

	rti_dot #(.CW(COORD_WIDTH)) u_dot (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_ctl      (front_ctl),
		.e1          (e1_w),
		.e2          (e2_w),
		.sv          (s_w),
		.dv          (d_w),
		.h           (h_w),
		.q           (q_w),
		.min_abs_det (min_abs_det_q),
		.ctl         (dot_ctl),
		.num         (num_w)
	);

	rti_div #(.NW(NW), .FRAC(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_ctl (dot_ctl),
		.num    (num_w),
		.ctl    (div_ctl),
		.quo_t  (quo_t_w),
		.quo_u  (quo_u_w),
		.quo_v  (quo_v_w)
	);

	assign hit_w = !div_ctl.miss && (quo_t_w > min_dist_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= div_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q  <= hit_w;
			dist_q <= hit_w ? quo_t_w : '0;
			u_q    <= hit_w ? quo_u_w : '0;
			v_q    <= hit_w ? quo_v_w : '0;
			w_q    <= hit_w ? (ONE - quo_u_w - quo_v_w) : '0;
		end
	end

	assign out_valid = vld_q;
	assign hit       = hit_q;
	assign distance  = dist_q;
	assign bary_u    = u_q;
	assign bary_v    = v_q;
	assign bary_w    = w_q;
endmodule

// ----- hdl/rti_checker.sv -----
`timescale 1ns / 1ps
`include "ray_triangle_intersect_core_assert.svh"
module rti_checker import rti_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic                  hit,
	input logic [DIST_WIDTH-1:0] distance,
	input logic [FRAC_BITS:0]    bary_u,
	input logic [FRAC_BITS:0]    bary_v,
	input logic [FRAC_BITS:0]    bary_w
);
	`RTI_ASSERT_HOLD(a_valid_hold, clk, arst_n, out_valid, out_stall, out_valid)
	`RTI_ASSERT_HOLD(a_dist_hold, clk, arst_n, out_valid, out_stall, distance)
	`RTI_ASSERT(a_miss_zero, clk, arst_n, (out_valid && !hit) |-> (distance == '0 && bary_u == '0 && bary_v == '0 && bary_w == '0))
	`RTI_ASSERT(a_hit_ahead, clk, arst_n, (out_valid && hit) |-> (distance != '0))
endmodule

bind ray_triangle_intersect_core rti_checker #(.FRAC_BITS(FRAC_BITS)) u_rti_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.hit       (hit),
	.distance  (distance),
	.bary_u    (bary_u),
	.bary_v    (bary_v),
	.bary_w    (bary_w)
);

// ----- verif/tb_ray_triangle_intersect_core.sv -----
`timescale 1ns / 1ps
module tb_ray_triangle_intersect_core;
	import rti_pkg::*;

	localparam logic [1:0] SEL_NONE = 2'd3;
	localparam int         ONE      = 65536;
	localparam int         MAX_GAP  = 12;
	localparam int         LATENCY  = 41;
	localparam int         WD_LIMIT = 20000;

	typedef logic signed [127:0] acc_t;

	typedef struct {
		func_t       fn;
		logic [1:0]  sel;
		logic [31:0] vert [3];
		logic [31:0] org  [3];
		logic [31:0] dir  [3];
	} ray_item_t;

	typedef struct {
		logic        hit;
		logic [30:0] distance;
		logic [16:0] u;
		logic [16:0] v;
		logic [16:0] w;
	} hit_rec_t;

	class hit_scoreboard;
		logic [31:0] tri_store [9];
		logic [31:0] det_floor;
		logic [30:0] dist_floor;
		hit_rec_t    expected [$];
		int          errors;

		function void reset();
			foreach (tri_store[i]) tri_store[i] = '0;
			det_floor  = 32'd1;
			dist_floor = 31'd1;
			expected.delete();
			errors = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [31:0] val);
			if (idx == CFG_MIN_ABS_DET) det_floor = val;
			else dist_floor = val[30:0];
		endfunction

		function acc_t sx(logic [31:0] x);
			return acc_t'($signed(x));
		endfunction

		function logic [63:0] ratio(acc_t n, acc_t d, logic [63:0] lim);
			logic [127:0] q;
			q = (128'(n) << 16) / 128'(d);
			return (q > 128'(lim)) ? lim : q[63:0];
		endfunction

		function void note_transfer(ray_item_t it);
			acc_t v0 [3], e1 [3], e2 [3], s [3], d [3], h [3], q [3];
			acc_t det, nu, nv, nt;
			logic [63:0] tq, uq, vq;
			hit_rec_t r;
			if (it.fn == FUNC_LOAD) begin
				if (it.sel != SEL_NONE)
					for (int i = 0; i < 3; i++) tri_store[it.sel * 3 + i] = it.vert[i];
				return;
			end
			r = '{0, 0, 0, 0, 0};
			for (int i = 0; i < 3; i++) begin
				v0[i] = sx(tri_store[i]);
				e1[i] = sx(tri_store[3 + i]) - v0[i];
				e2[i] = sx(tri_store[6 + i]) - v0[i];
				s[i]  = sx(it.org[i]) - v0[i];
				d[i]  = sx(it.dir[i]);
			end
			h[0] = d[1] * e2[2] - d[2] * e2[1];
			h[1] = d[2] * e2[0] - d[0] * e2[2];
			h[2] = d[0] * e2[1] - d[1] * e2[0];
			q[0] = s[1] * e1[2] - s[2] * e1[1];
			q[1] = s[2] * e1[0] - s[0] * e1[2];
			q[2] = s[0] * e1[1] - s[1] * e1[0];
			det = e1[0] * h[0] + e1[1] * h[1] + e1[2] * h[2];
			nu  = s[0] * h[0] + s[1] * h[1] + s[2] * h[2];
			nv  = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
			nt  = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
			if (det < 0) begin
				det = -det;
				nu  = -nu;
				nv  = -nv;
				nt  = -nt;
			end
			if (det != 0 && det >= acc_t'({96'b0, det_floor}) && nu >= 0 && nu <= det
					&& nv >= 0 && nu + nv <= det && nt >= 0) begin
				tq = ratio(nt, det, 64'h7FFF_FFFF);
				if (tq > {33'b0, dist_floor}) begin
					uq = ratio(nu, det, ONE);
					vq = ratio(nv, det, ONE);
					r.hit      = 1'b1;
					r.distance = tq[30:0];
					r.u        = uq[16:0];
					r.v        = vq[16:0];
					r.w        = 17'(ONE - uq - vq);
				end
			end
			expected.push_back(r);
		endfunction

		function void check(hit_rec_t got);
			hit_rec_t e;
			if (expected.size() == 0) begin
				$error("result with nothing expected");
				errors++;
				return;
			end
			e = expected.pop_front();
			if (got.hit !== e.hit) begin
				$error("hit: expected %0d, actual %0d", e.hit, got.hit); errors++;
			end
			if (got.distance !== e.distance) begin
				$error("distance: expected %0h, actual %0h", e.distance, got.distance); errors++;
			end
			if (got.u !== e.u) begin
				$error("bary_u: expected %0h, actual %0h", e.u, got.u); errors++;
			end
			if (got.v !== e.v) begin
				$error("bary_v: expected %0h, actual %0h", e.v, got.v); errors++;
			end
			if (got.w !== e.w) begin
				$error("bary_w: expected %0h, actual %0h", e.w, got.w); errors++;
			end
		endfunction

		function int pending();
			return expected.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, in_stall;
	logic func = 1'b0;
	logic [1:0] vertex_sel = '0;
	logic signed [31:0] vert_x = '0, vert_y = '0, vert_z = '0;
	logic signed [31:0] origin_x = '0, origin_y = '0, origin_z = '0;
	logic signed [31:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic out_valid, out_stall = 1'b0, hit;
	logic [DIST_WIDTH-1:0] distance;
	logic [16:0] bary_u, bary_v, bary_w;
	logic cfg_we = 1'b0, cfg_addr = 1'b0;
	logic [MDET_WIDTH-1:0] cfg_wdata = '0;

	hit_scoreboard sb = new();
	bit burst = 0;
	int idle_cycles = 0;
	longint tri_v [3][3];

	ray_triangle_intersect_core dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check('{hit, distance, bary_u, bary_v, bary_w});
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else if (++idle_cycles >= WD_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = burst ? 0 : $urandom_range(0, MAX_GAP);
			repeat (n) begin
				@(negedge clk) out_stall = 1'b1;
			end
			@(negedge clk) out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send(ray_item_t it);
		int gap;
		gap = burst ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			@(negedge clk) in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		func = it.fn;
		vertex_sel = it.sel;
		{vert_x, vert_y, vert_z} = {it.vert[0], it.vert[1], it.vert[2]};
		{origin_x, origin_y, origin_z} = {it.org[0], it.org[1], it.org[2]};
		{dir_x, dir_y, dir_z} = {it.dir[0], it.dir[1], it.dir[2]};
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_transfer(it);
		if ($urandom_range(0, 49) == 0) burst = ~burst;
	endtask

	task automatic drain();
		@(negedge clk) in_valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_addr = idx;
		cfg_wdata = val;
		sb.set_reg(idx, val);
		@(negedge clk) cfg_we = 1'b0;
	endtask

	function automatic ray_item_t noise_item();
		ray_item_t it;
		it.fn  = func_t'($urandom_range(0, 1));
		it.sel = 2'($urandom_range(0, 3));
		for (int i = 0; i < 3; i++) begin
			it.vert[i] = $urandom;
			it.org[i]  = $urandom;
			it.dir[i]  = $urandom;
		end
		return it;
	endfunction

	function automatic ray_item_t load_item(int sel, longint x, longint y, longint z);
		ray_item_t it = noise_item();
		it.fn = FUNC_LOAD;
		it.sel = 2'(sel);
		it.vert[0] = 32'(x);
		it.vert[1] = 32'(y);
		it.vert[2] = 32'(z);
		return it;
	endfunction

	function automatic ray_item_t ray_item(longint o [3], longint d [3]);
		ray_item_t it = noise_item();
		it.fn = FUNC_RAY;
		for (int i = 0; i < 3; i++) begin
			it.org[i] = 32'(o[i]);
			it.dir[i] = 32'(d[i]);
		end
		return it;
	endfunction

	function automatic ray_item_t aimed_ray();
		longint o [3], d [3];
		int a, b, k;
		a = $urandom_range(0, 256);
		b = $urandom_range(0, 256 - a);
		k = $urandom_range(0, 3);
		for (int i = 0; i < 3; i++) begin
			o[i] = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
			d[i] = tri_v[0][i] + (a * (tri_v[1][i] - tri_v[0][i])
				+ b * (tri_v[2][i] - tri_v[0][i])) / 256 - o[i];
			d[i] = d[i] >>> k;
		end
		if ($urandom_range(0, 7) == 0)
			for (int i = 0; i < 3; i++) d[i] = -d[i];
		return ray_item(o, d);
	endfunction

	task automatic new_triangle();
		for (int v = 0; v < 3; v++) begin
			for (int i = 0; i < 3; i++)
				tri_v[v][i] = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
			send(load_item(v, tri_v[v][0], tri_v[v][1], tri_v[v][2]));
		end
	endtask

	task automatic run_random(int count);
		int sent = 0, r;
		new_triangle();
		while (sent < count) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				send(noise_item());
				sent++;
			end else if (r < 18) begin
				new_triangle();
				sent += 3;
			end else begin
				send(aimed_ray());
				sent++;
			end
		end
	endtask

	initial begin
		longint o [3], d [3];
		sb.reset();
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		o = '{0, 0, 0};
		d = '{0, 0, ONE};
		send(ray_item(o, d));
		send(load_item(0, 0, 0, 2 * ONE));
		send(load_item(1, ONE, 0, 2 * ONE));
		send(load_item(2, 0, ONE, 2 * ONE));
		send(load_item(SEL_NONE, 32'h8000_0000, 32'h7FFF_FFFF, -1));
		o = '{ONE / 4, ONE / 4, 0};
		send(ray_item(o, d));
		d = '{0, 0, -ONE};
		send(ray_item(o, d));
		o = '{0, 0, 0};
		d = '{0, 0, ONE};
		send(ray_item(o, d));
		o = '{ONE, 0, 0};
		send(ray_item(o, d));
		o = '{ONE / 2, ONE / 2, 0};
		send(ray_item(o, d));
		o = '{ONE / 4, ONE / 4, 0};
		d = '{ONE, 0, 0};
		send(ray_item(o, d));
		d = '{0, 0, 1};
		send(ray_item(o, d));
		o = '{-ONE, -ONE, 0};
		d = '{0, 0, ONE};
		send(ray_item(o, d));
		o = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000};
		d = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF};
		send(ray_item(o, d));
		send(load_item(0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
		send(load_item(1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF));
		send(load_item(2, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
		o = '{0, 0, 32'sh8000_0000};
		d = '{0, 0, 1};
		send(ray_item(o, d));
		d = '{-1, -1, 32'sh7FFF_FFFF};
		send(ray_item(o, d));
		drain();

		write_reg(CFG_MIN_ABS_DET, 32'd0);
		write_reg(CFG_MIN_DIST, 32'd0);
		run_random(290);
		drain();
		write_reg(CFG_MIN_ABS_DET, 32'hFFFF_FFFF);
		write_reg(CFG_MIN_DIST, 32'h7FFF_FFFF);
		run_random(150);
		drain();
		write_reg(CFG_MIN_ABS_DET, $urandom);
		write_reg(CFG_MIN_DIST, $urandom_range(0, 2 * ONE));
		run_random(330);
		drain();
		write_reg(CFG_MIN_ABS_DET, 32'd1);
		write_reg(CFG_MIN_DIST, 32'd1);
		run_random(330);
		drain();
		write_reg(CFG_MIN_ABS_DET, $urandom_range(0, 1 << 20));
		write_reg(CFG_MIN_DIST, $urandom_range(0, ONE));
		run_random(330);
		drain();

		if (sb.pending() != 0) sb.errors++;
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

// ----- ray_triangle_intersect_core.f -----
+incdir+hdl
hdl/rti_pkg.sv
hdl/rti_front.sv
hdl/rti_dot.sv
hdl/rti_div.sv
hdl/ray_triangle_intersect_core.sv
hdl/rti_checker.sv
verif/tb_ray_triangle_intersect_core.sv
